[sv/rfdp_pkg.sv]
// Shared types and constants of the receive-frame dispatcher with buffer pool.
package rfdp_pkg;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FRAME = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_GRANTED  = 3'd0,
		KIND_REFUSED  = 3'd1,
		KIND_DELIVER  = 3'd2,
		KIND_COPY     = 3'd3,
		KIND_DROPPED  = 3'd4,
		KIND_READ     = 3'd5,
		KIND_EMPTY    = 3'd6,
		KIND_RSVD     = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		REG_CLIENT_COUNT = 3'd0,
		REG_MAC0         = 3'd1,
		REG_MAC1         = 3'd2,
		REG_MAC2         = 3'd3,
		REG_MAC3         = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_ALLOC_WR,
		ST_MATCH,
		ST_COPY_CHK,
		ST_COPY_WR,
		ST_FINAL,
		ST_READ
	} state_t;

	localparam int NUM_MAC = 4;
	localparam logic [11:0] MIN_MAC_LEN = 12'd6;
	// Ethernet header, IPv4 header up to the destination, and the address itself.
	localparam logic [11:0] MIN_MC_LEN  = 12'd14 + 12'd16 + 12'd4;
	localparam logic [7:0]  IP_MC_MASK  = 8'hf0;
	localparam logic [7:0]  IP_MC_VAL   = 8'he0;
	localparam logic [47:0] MAC_BCAST   = 48'hffff_ffff_ffff;

	typedef struct packed {
		logic [2:0]               client_count;
		logic [NUM_MAC-1:0][47:0] mac;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  client;
		logic [7:0]  buffer;
		logic [7:0]  source;
		logic [11:0] length;
		logic        notify;
		logic        more;
		logic        last;
	} result_t;

endpackage

[sv/rx_frame_dispatch_buffer_pool_unit.sv]
// Top level: configuration registers and result ports of the frame dispatcher.
//
// channel   direction  handshake               payload
// command   in         start & !busy           cmd, client_sel, buffer_in, frame_len,
//                                              dest_mac, ip_dest_first
// result    out        strobe, one cycle       kind, client_out, buffer_out, source_buffer,
//                                              length_out, notify, more_pending, last
// config    in         wr_en                   wr_index, wr_data
//
// A granted allocate runs ST_ALLOC and ST_ALLOC_WR, a read of a waiting frame two ST_READ
// passes, a refused allocate or an empty read ST_ALLOC or ST_READ alone; each result shows
// in the next cycle. A frame takes an ST_MATCH step per compared client MAC, plus one when
// none matches (an unknown unicast frame is dropped there), ST_COPY_CHK and ST_COPY_WR per
// copy, ST_COPY_CHK per skipped client and to close the copy loop, and ST_FINAL to deliver
// or drop. A frame shorter than six bytes skips the compares. The single MAC comparator
// and the registered RAM reads set these steps. Reset clears the ring pointers, sets the
// pool full and arms the notify flags at once; no clearing pass is needed. The receiver cannot stall.
module rx_frame_dispatch_buffer_pool_unit #(
	parameter int POOL_DEPTH  = 256,
	parameter int RING_DEPTH  = 128,
	parameter int MAX_CLIENTS = 4,
	parameter int MAX_FRAME   = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [47:0] wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [1:0]  client_sel,
	input  logic [7:0]  buffer_in,
	input  logic [11:0] frame_len,
	input  logic [47:0] dest_mac,
	input  logic [7:0]  ip_dest_first,
	output logic        strobe,
	output logic [2:0]  kind,
	output logic [1:0]  client_out,
	output logic [7:0]  buffer_out,
	output logic [7:0]  source_buffer,
	output logic [11:0] length_out,
	output logic        notify,
	output logic        more_pending,
	output logic        last
);
	import rfdp_pkg::*;

	cfg_t    cfg_q;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.client_count <= 3'd1;
			cfg_q.mac          <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_CLIENT_COUNT: cfg_q.client_count <= wr_data[2:0];
				REG_MAC0:         cfg_q.mac[0] <= wr_data;
				REG_MAC1:         cfg_q.mac[1] <= wr_data;
				REG_MAC2:         cfg_q.mac[2] <= wr_data;
				REG_MAC3:         cfg_q.mac[3] <= wr_data;
				default:          ;
			endcase
		end
	end

	rfdp_seq #(
		.POOL_DEPTH(POOL_DEPTH), .RING_DEPTH(RING_DEPTH),
		.MAX_CLIENTS(MAX_CLIENTS), .MAX_FRAME(MAX_FRAME)
	) u_seq (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .start(start), .cmd(cmd),
		.client_sel(client_sel), .buffer_in(buffer_in), .frame_len(frame_len),
		.dest_mac(dest_mac), .ip_dest_first(ip_dest_first), .busy(busy),
		.res_vld(strobe), .res(res)
	);

	assign kind          = res.kind;
	assign client_out    = res.client;
	assign buffer_out    = res.buffer;
	assign source_buffer = res.source;
	assign length_out    = res.length;
	assign notify        = res.notify;
	assign more_pending  = res.more;
	assign last          = res.last;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd != CMD_NONE) |=> busy)
		else $error("command transfer did not make the block busy");

	a_copy_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_COPY) |-> (!last && client_out != 2'd0))
		else $error("copy result marked last or sent to client 0");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_REFUSED) |-> (buffer_out == 8'd0 && length_out == 12'd0))
		else $error("refused allocation carries a handle");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("block idle before the final result");
endmodule

[sv/rfdp_ram.sv]
// Generic simple dual-port RAM with registered read.
module rfdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/rfdp_seq.sv]
// Sequencer with shared MAC compare, free-handle stack and client rings.
module rfdp_seq #(
	parameter int POOL_DEPTH  = 256,
	parameter int RING_DEPTH  = 128,
	parameter int MAX_CLIENTS = 4,
	parameter int MAX_FRAME   = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rfdp_pkg::cfg_t    cfg,
	input  logic              start,
	input  logic [1:0]        cmd,
	input  logic [1:0]        client_sel,
	input  logic [7:0]        buffer_in,
	input  logic [11:0]       frame_len,
	input  logic [47:0]       dest_mac,
	input  logic [7:0]        ip_dest_first,
	output logic              busy,
	output logic              res_vld,
	output rfdp_pkg::result_t res
);
	import rfdp_pkg::*;

	localparam int SA  = POOL_DEPTH > 1 ? $clog2(POOL_DEPTH) : 1;
	localparam int FCW = $clog2(POOL_DEPTH + 1);
	localparam int PW  = RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1;
	localparam int RD  = MAX_CLIENTS * RING_DEPTH;
	localparam int RA  = RD > 1 ? $clog2(RD) : 1;
	localparam int CIW = MAX_CLIENTS > 1 ? $clog2(MAX_CLIENTS) : 1;

	state_t state_q, state_d;
	cmd_t   cmd_q, cmd_d;
	logic [7:0]  buf_q, buf_d;
	logic [11:0] len_q, len_d;
	logic [47:0] mac_q, mac_d;
	logic [7:0]  ip_q, ip_d;
	logic [2:0]  cli_q, cli_d;
	logic [FCW-1:0] fc_q, fc_d, low_q, low_d, pop_idx;
	logic init_q, init_d;
	logic [7:0] rst_q, rst_d;
	logic [PW-1:0] head_q [MAX_CLIENTS];
	logic [PW-1:0] head_d [MAX_CLIENTS];
	logic [PW-1:0] tail_q [MAX_CLIENTS];
	logic [PW-1:0] tail_d [MAX_CLIENTS];
	logic [MAX_CLIENTS-1:0] armed_q, armed_d;
	result_t res_q, res_d;
	logic    vld_q, vld_d;

	logic          st_we;
	logic [SA-1:0] st_waddr, st_raddr;
	logic [7:0]    st_wdata, st_rdata, pop_handle;
	logic          rg_we;
	logic [RA-1:0] rg_waddr, rg_raddr, rg_base;
	logic [19:0]   rg_wdata, rg_rdata;

	logic [CIW-1:0] cur;
	logic [PW-1:0]  hd, tl, hd_nx, tl_nx;
	logic [2:0]     nc;
	logic           full, len_ok, pool_ok, lenge6, bcast, mcast, more;

	rfdp_ram #(.WIDTH(8), .DEPTH(POOL_DEPTH)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	rfdp_ram #(.WIDTH(20), .DEPTH(RD)) u_ring (
		.clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
		.raddr(rg_raddr), .rdata(rg_rdata)
	);

	always_comb begin
		cur     = cli_q[CIW-1:0];
		hd      = head_q[cur];
		tl      = tail_q[cur];
		hd_nx   = (hd == PW'(RING_DEPTH - 1)) ? '0 : hd + PW'(1);
		tl_nx   = (tl == PW'(RING_DEPTH - 1)) ? '0 : tl + PW'(1);
		full    = (hd_nx == tl);
		rg_base = RA'(cur) * RA'(RING_DEPTH);
		if (cfg.client_count == 3'd0) begin
			nc = 3'd1;
		end else if (cfg.client_count > 3'(MAX_CLIENTS)) begin
			nc = 3'(MAX_CLIENTS);
		end else begin
			nc = cfg.client_count;
		end
		len_ok  = ({1'b0, len_q} <= 13'(MAX_FRAME));
		pool_ok = len_ok && (fc_q != '0);
		lenge6  = (len_q >= MIN_MAC_LEN);
		bcast   = lenge6 && (mac_q == MAC_BCAST);
		mcast   = (len_q >= MIN_MC_LEN) && ((ip_q & IP_MC_MASK) == IP_MC_VAL);
		pop_idx = fc_q - FCW'(1);
		// Stack entries below the lowest depth ever reached still hold reset values.
		pop_handle = init_q ? rst_q : st_rdata;
		more    = (tl != hd);
	end

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		buf_d   = buf_q;
		len_d   = len_q;
		mac_d   = mac_q;
		ip_d    = ip_q;
		cli_d   = cli_q;
		fc_d    = fc_q;
		low_d   = low_q;
		init_d  = init_q;
		rst_d   = rst_q;
		head_d  = head_q;
		tail_d  = tail_q;
		armed_d = armed_q;
		res_d   = res_q;
		vld_d   = 1'b0;
		st_we    = 1'b0;
		st_waddr = SA'(fc_q);
		st_wdata = buf_q;
		st_raddr = SA'(pop_idx);
		rg_we    = 1'b0;
		rg_waddr = rg_base + RA'(hd);
		rg_wdata = {buf_q, len_q};
		rg_raddr = rg_base + RA'(tl);

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_d = cmd_t'(cmd);
					buf_d = buffer_in;
					len_d = frame_len;
					mac_d = dest_mac;
					ip_d  = ip_dest_first;
					cli_d = (cmd_t'(cmd) == CMD_READ) ? {1'b0, client_sel} : 3'd0;
					unique case (cmd_t'(cmd))
						CMD_ALLOC: state_d = ST_ALLOC;
						CMD_FRAME: state_d = ST_MATCH;
						CMD_READ:  state_d = ST_READ;
						CMD_NONE:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ALLOC: begin
				if (pool_ok) begin
					fc_d    = pop_idx;
					init_d  = (pop_idx < low_q);
					rst_d   = 8'(pop_idx);
					low_d   = (pop_idx < low_q) ? pop_idx : low_q;
					state_d = ST_ALLOC_WR;
				end else begin
					res_d   = '{kind: KIND_REFUSED, default: '0};
					res_d.last = 1'b1;
					vld_d   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ALLOC_WR: begin
				res_d        = '{kind: KIND_GRANTED, default: '0};
				res_d.buffer = pop_handle;
				res_d.last   = 1'b1;
				vld_d        = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_MATCH: begin
				// One client MAC is compared per cycle, lowest index first.
				if (!lenge6 || cli_q >= nc) begin
					if (bcast || mcast) begin
						cli_d   = 3'd1;
						state_d = ST_COPY_CHK;
					end else begin
						if (fc_q != FCW'(POOL_DEPTH)) begin
							st_we = 1'b1;
							fc_d  = fc_q + FCW'(1);
						end
						res_d        = '{kind: KIND_DROPPED, default: '0};
						res_d.buffer = buf_q;
						res_d.length = len_q;
						res_d.last   = 1'b1;
						vld_d        = 1'b1;
						state_d      = ST_IDLE;
					end
				end else if (cfg.mac[cli_q[1:0]] == mac_q) begin
					state_d = ST_FINAL;
				end else begin
					cli_d = cli_q + 3'd1;
				end
			end
			ST_COPY_CHK: begin
				if (cli_q >= nc) begin
					cli_d   = 3'd0;
					state_d = ST_FINAL;
				end else if (!full && pool_ok) begin
					fc_d    = pop_idx;
					init_d  = (pop_idx < low_q);
					rst_d   = 8'(pop_idx);
					low_d   = (pop_idx < low_q) ? pop_idx : low_q;
					state_d = ST_COPY_WR;
				end else begin
					cli_d = cli_q + 3'd1;
				end
			end
			ST_COPY_WR: begin
				rg_we         = 1'b1;
				rg_wdata      = {pop_handle, len_q};
				head_d[cur]   = hd_nx;
				armed_d[cur]  = 1'b0;
				res_d         = '{kind: KIND_COPY, default: '0};
				res_d.client  = cli_q[1:0];
				res_d.buffer  = pop_handle;
				res_d.source  = buf_q;
				res_d.length  = len_q;
				res_d.notify  = armed_q[cur];
				vld_d         = 1'b1;
				cli_d         = cli_q + 3'd1;
				state_d       = ST_COPY_CHK;
			end
			ST_FINAL: begin
				if (full) begin
					if (fc_q != FCW'(POOL_DEPTH)) begin
						st_we = 1'b1;
						fc_d  = fc_q + FCW'(1);
					end
					res_d        = '{kind: KIND_DROPPED, default: '0};
				end else begin
					rg_we        = 1'b1;
					head_d[cur]  = hd_nx;
					armed_d[cur] = 1'b0;
					res_d        = '{kind: KIND_DELIVER, default: '0};
					res_d.client = cli_q[1:0];
					res_d.notify = armed_q[cur];
				end
				res_d.buffer = buf_q;
				res_d.length = len_q;
				res_d.last   = 1'b1;
				vld_d        = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_READ: begin
				if (cmd_q == CMD_READ) begin
					if (cli_q >= nc || !more) begin
						if (cli_q < nc) begin
							armed_d[cur] = 1'b1;
						end
						res_d        = '{kind: KIND_EMPTY, default: '0};
						res_d.client = cli_q[1:0];
						res_d.last   = 1'b1;
						vld_d        = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						tail_d[cur] = tl_nx;
						// Marks the second pass, in which the ring data has arrived.
						cmd_d       = CMD_NONE;
					end
				end else begin
					if (!more) begin
						armed_d[cur] = 1'b1;
					end
					if (fc_q != FCW'(POOL_DEPTH)) begin
						st_we = 1'b1;
						fc_d  = fc_q + FCW'(1);
					end
					st_wdata     = rg_rdata[19:12];
					res_d        = '{kind: KIND_READ, default: '0};
					res_d.client = cli_q[1:0];
					res_d.buffer = rg_rdata[19:12];
					res_d.length = rg_rdata[11:0];
					res_d.more   = more;
					res_d.last   = 1'b1;
					vld_d        = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cli_q   <= '0;
			cmd_q   <= CMD_NONE;
			fc_q    <= FCW'(POOL_DEPTH);
			low_q   <= FCW'(POOL_DEPTH);
			init_q  <= 1'b0;
			armed_q <= '1;
			vld_q   <= 1'b0;
			for (int i = 0; i < MAX_CLIENTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			cli_q   <= cli_d;
			cmd_q   <= cmd_d;
			fc_q    <= fc_d;
			low_q   <= low_d;
			init_q  <= init_d;
			armed_q <= armed_d;
			vld_q   <= vld_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_d;
		len_q <= len_d;
		mac_q <= mac_d;
		ip_q  <= ip_d;
		rst_q <= rst_d;
		res_q <= res_d;
	end

	assign busy    = (state_q != ST_IDLE);
	assign res_vld = vld_q;
	assign res     = res_q;
endmodule

[verif/rx_frame_dispatch_buffer_pool_unit_tb.sv]
// Testbench of the receive-frame dispatcher: directed and random commands against a predictor.
`timescale 1ns / 1ps

module rx_frame_dispatch_buffer_pool_unit_tb;
	import rfdp_pkg::*;

	localparam int POOL_N  = 256;
	localparam int RING_N  = 128;
	localparam int CLI_N   = 4;
	localparam int FRM_MAX = 2048;
	localparam int LIMIT   = 400000;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [47:0] wr_data;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [1:0]  client_sel;
	logic [7:0]  buffer_in;
	logic [11:0] frame_len;
	logic [47:0] dest_mac;
	logic [7:0]  ip_dest_first;
	logic        strobe;
	logic [2:0]  kind;
	logic [1:0]  client_out;
	logic [7:0]  buffer_out;
	logic [7:0]  source_buffer;
	logic [11:0] length_out;
	logic        notify;
	logic        more_pending;
	logic        last;

	rx_frame_dispatch_buffer_pool_unit uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.start(start), .busy(busy), .cmd(cmd), .client_sel(client_sel),
		.buffer_in(buffer_in), .frame_len(frame_len), .dest_mac(dest_mac),
		.ip_dest_first(ip_dest_first), .strobe(strobe), .kind(kind),
		.client_out(client_out), .buffer_out(buffer_out), .source_buffer(source_buffer),
		.length_out(length_out), .notify(notify), .more_pending(more_pending), .last(last)
	);

	// Predictor state.
	logic [2:0]  m_count;
	logic [47:0] m_mac [CLI_N];
	logic [7:0]  m_stack [POOL_N];
	int          m_free;
	logic [7:0]  m_rhandle [CLI_N][RING_N];
	logic [11:0] m_rlen [CLI_N][RING_N];
	int          m_head [CLI_N];
	int          m_tail [CLI_N];
	logic        m_armed [CLI_N];

	result_t     expected_results [$];
	int          errors;
	int          cycles;
	bit          idling;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				report("unexpected result kind", kind, 0);
			end else begin
				e = expected_results.pop_front();
				if (kind != e.kind) report("kind", kind, e.kind);
				if (client_out != e.client) report("client_out", client_out, e.client);
				if (buffer_out != e.buffer) report("buffer_out", buffer_out, e.buffer);
				if (source_buffer != e.source) report("source_buffer", source_buffer, e.source);
				if (length_out != e.length) report("length_out", length_out, e.length);
				if (notify != e.notify) report("notify", notify, e.notify);
				if (more_pending != e.more) report("more_pending", more_pending, e.more);
				if (last != e.last) report("last", last, e.last);
			end
		end
	end

	function automatic int active_count();
		if (m_count == 0) return 1;
		if (m_count > CLI_N) return CLI_N;
		return m_count;
	endfunction

	function automatic bit ring_full(int c);
		return ((m_head[c] + 1) % RING_N) == m_tail[c];
	endfunction

	function automatic bit pool_pop(logic [11:0] size, output logic [7:0] h);
		h = 8'd0;
		if (size > FRM_MAX || m_free == 0) return 0;
		m_free--;
		h = m_stack[m_free];
		return 1;
	endfunction

	function automatic void pool_push(logic [7:0] h);
		if (m_free >= POOL_N) return;
		m_stack[m_free] = h;
		m_free++;
	endfunction

	function automatic logic ring_put(int c, logic [7:0] h, logic [11:0] len);
		logic nt;
		m_rhandle[c][m_head[c]] = h;
		m_rlen[c][m_head[c]] = len;
		m_head[c] = (m_head[c] + 1) % RING_N;
		nt = m_armed[c];
		m_armed[c] = 1'b0;
		return nt;
	endfunction

	function automatic result_t mk(kind_t k, int c, logic [7:0] b, logic [7:0] s,
			logic [11:0] len, logic nt, logic mr);
		result_t r;
		r.kind = k; r.client = 2'(c); r.buffer = b; r.source = s;
		r.length = len; r.notify = nt; r.more = mr; r.last = 1'b0;
		return r;
	endfunction

	// Computes the results of one accepted command and queues them.
	function automatic void predict_dispatch(cmd_t c, logic [1:0] sel, logic [7:0] b,
			logic [11:0] len, logic [47:0] mac, logic [7:0] ip);
		result_t out [$];
		logic [7:0] h;
		int nc, tgt, t;
		bit found, bc, mc;
		nc = active_count();
		tgt = 0;
		found = 0;
		case (c)
			CMD_ALLOC: begin
				if (pool_pop(len, h)) out.push_back(mk(KIND_GRANTED, 0, h, 0, 0, 0, 0));
				else out.push_back(mk(KIND_REFUSED, 0, 0, 0, 0, 0, 0));
			end
			CMD_FRAME: begin
				if (len >= 6)
					for (int i = 0; i < nc && !found; i++)
						if (m_mac[i] == mac) begin
							tgt = i;
							found = 1;
						end
				if (!found) begin
					bc = (len >= 6) && (mac == MAC_BCAST);
					mc = (len >= 34) && ((ip & IP_MC_MASK) == IP_MC_VAL);
					if (!bc && !mc) begin
						pool_push(b);
						out.push_back(mk(KIND_DROPPED, 0, b, 0, len, 0, 0));
					end else begin
						for (int i = 1; i < nc; i++) begin
							if (ring_full(i)) continue;
							if (!pool_pop(len, h)) continue;
							out.push_back(mk(KIND_COPY, i, h, b, len, ring_put(i, h, len), 0));
						end
					end
				end
				if (found || bc || mc) begin
					if (ring_full(tgt)) begin
						pool_push(b);
						out.push_back(mk(KIND_DROPPED, 0, b, 0, len, 0, 0));
					end else begin
						out.push_back(mk(KIND_DELIVER, tgt, b, 0, len, ring_put(tgt, b, len), 0));
					end
				end
			end
			CMD_READ: begin
				if (sel >= nc) begin
					out.push_back(mk(KIND_EMPTY, sel, 0, 0, 0, 0, 0));
				end else if (m_head[sel] == m_tail[sel]) begin
					m_armed[sel] = 1'b1;
					out.push_back(mk(KIND_EMPTY, sel, 0, 0, 0, 0, 0));
				end else begin
					t = m_tail[sel];
					m_tail[sel] = (t + 1) % RING_N;
					if (m_tail[sel] == m_head[sel]) m_armed[sel] = 1'b1;
					pool_push(m_rhandle[sel][t]);
					out.push_back(mk(KIND_READ, sel, m_rhandle[sel][t], 0, m_rlen[sel][t], 0,
						m_tail[sel] != m_head[sel]));
				end
			end
			default: ;
		endcase
		if (out.size() > 0) out[out.size() - 1].last = 1'b1;
		foreach (out[i]) expected_results.push_back(out[i]);
	endfunction

	// Offers one command and holds it until the block takes it; called at a rising edge.
	task automatic send_cmd(cmd_t c, logic [1:0] sel, logic [7:0] b, logic [11:0] len,
			logic [47:0] mac, logic [7:0] ip);
		int gap;
		start <= 1'b1;
		cmd <= c;
		client_sel <= sel;
		buffer_in <= b;
		frame_len <= len;
		dest_mac <= mac;
		ip_dest_first <= ip;
		do @(posedge clk); while (!(start && !busy));
		predict_dispatch(c, sel, b, len, mac, ip);
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		wait (expected_results.size() == 0);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Drives one register write; the caller drops the write enable after a sequence.
	task automatic write_reg(reg_idx_t idx, logic [47:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		if (idx == REG_CLIENT_COUNT) m_count = val[2:0];
		else m_mac[idx - 1] = val;
	endtask

	task automatic setup(logic [2:0] n, logic [47:0] a0, logic [47:0] a1, logic [47:0] a2,
			logic [47:0] a3);
		wait_quiet();
		write_reg(REG_CLIENT_COUNT, 48'(n));
		write_reg(REG_MAC0, a0);
		write_reg(REG_MAC1, a1);
		write_reg(REG_MAC2, a2);
		write_reg(REG_MAC3, a3);
		wr_en <= 1'b0;
	endtask

	task automatic test_directed();
		send_cmd(CMD_ALLOC, 0, 0, 12'd0, 0, 0);
		send_cmd(CMD_ALLOC, 0, 0, 12'd2048, 0, 0);
		send_cmd(CMD_ALLOC, 0, 0, 12'd2049, 0, 0);
		send_cmd(CMD_ALLOC, 0, 0, 12'hfff, 0, 0);
		send_cmd(CMD_READ, 2'd0, 0, 0, 0, 0);
		send_cmd(CMD_READ, 2'd3, 0, 0, 0, 0);
		send_cmd(CMD_NONE, 2'd3, 8'hff, 12'hfff, '1, 8'hff);
		// With all MACs zero a zero destination matches client 0 only from length 6 up.
		send_cmd(CMD_FRAME, 0, 8'd5, 12'd5, 48'd0, 8'd0);
		send_cmd(CMD_FRAME, 0, 8'd6, 12'd6, 48'd0, 8'd0);
		setup(3'd4, 48'h0000_0000_0000, 48'h0200_0000_0001, 48'hffff_ffff_ffff,
			48'h0200_0000_0003);
		send_cmd(CMD_FRAME, 0, 8'd10, 12'd64, 48'h0200_0000_0001, 8'h0a);
		send_cmd(CMD_FRAME, 0, 8'd11, 12'd3000, 48'h0200_0000_0003, 8'h0a);
		send_cmd(CMD_FRAME, 0, 8'd12, 12'd60, 48'h1234_5678_9abc, 8'h0a);
		send_cmd(CMD_FRAME, 0, 8'd13, 12'd34, 48'h1234_5678_9abc, 8'he0);
		send_cmd(CMD_FRAME, 0, 8'd14, 12'd33, 48'h1234_5678_9abc, 8'hef);
		send_cmd(CMD_FRAME, 0, 8'd15, 12'd2049, 48'h1234_5678_9abc, 8'hef);
		setup(3'd7, 48'h0a0b_0c0d_0e0f, 48'h0200_0000_0001, 48'h0200_0000_0001,
			48'h0200_0000_0003);
		send_cmd(CMD_FRAME, 0, 8'd16, 12'd100, 48'hffff_ffff_ffff, 8'h00);
		for (int i = 0; i < 4; i++) send_cmd(CMD_READ, 2'(i), 0, 0, 0, 0);
		send_cmd(CMD_READ, 2'd1, 0, 0, 0, 0);
		send_cmd(CMD_FRAME, 0, 8'd17, 12'd100, 48'h0200_0000_0001, 8'h00);
	endtask

	task automatic test_ring_full();
		setup(3'd2, 48'h0000_0000_00aa, 48'h0000_0000_00bb, 0, 0);
		for (int i = 0; i < RING_N; i++)
			send_cmd(CMD_FRAME, 0, 8'(i), 12'(100 + i), 48'h0000_0000_00bb, 8'h00);
		send_cmd(CMD_FRAME, 0, 8'd200, 12'd64, 48'hffff_ffff_ffff, 8'h00);
		for (int i = 0; i < RING_N + 1; i++) send_cmd(CMD_READ, 2'd1, 0, 0, 0, 0);
		send_cmd(CMD_READ, 2'd0, 0, 0, 0, 0);
	endtask

	task automatic test_pool_empty();
		setup(3'd0, 48'h0000_0000_00aa, 48'h0000_0000_00bb, 0, 0);
		for (int i = 0; i < POOL_N + 3; i++)
			send_cmd(CMD_ALLOC, 0, 0, 12'($urandom_range(0, 2048)), 0, 0);
		setup(3'd4, 48'h0000_0000_00aa, 48'h0000_0000_00bb, 48'h0000_0000_00cc, 0);
		send_cmd(CMD_FRAME, 0, 8'd1, 12'd64, 48'hffff_ffff_ffff, 8'h00);
		// Unknown unicast frames hand handles back; pushes past a full stack are ignored.
		for (int i = 0; i < POOL_N + 2; i++)
			send_cmd(CMD_FRAME, 0, 8'(i), 12'd64, 48'h1, 8'h00);
	endtask

	task automatic test_random(int n);
		logic [47:0] mac;
		logic [11:0] len;
		logic [7:0]  ip;
		int r;
		for (int i = 0; i < n; i++) begin
			idling = (i < n * 4 / 5);
			r = $urandom_range(0, 99);
			if (r < 20) begin
				len = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2048));
				send_cmd(CMD_ALLOC, 2'($urandom), 8'($urandom), len,
					48'({$urandom, $urandom}), 8'($urandom));
			end else if (r < 60) begin
				r = $urandom_range(0, 99);
				if (r < 45) mac = m_mac[$urandom_range(0, 3)];
				else if (r < 65) mac = MAC_BCAST;
				else mac = 48'({$urandom, $urandom});
				r = $urandom_range(0, 9);
				len = (r == 0) ? 12'($urandom_range(0, 7)) :
					(r == 1) ? 12'($urandom) : 12'($urandom_range(30, 2048));
				ip = ($urandom_range(0, 2) == 0) ? {4'he, 4'($urandom)} : 8'($urandom);
				send_cmd(CMD_FRAME, 2'($urandom), 8'($urandom), len, mac, ip);
			end else if (r < 97) begin
				send_cmd(CMD_READ, 2'($urandom), 8'($urandom), 12'($urandom),
					48'({$urandom, $urandom}), 8'($urandom));
			end else begin
				send_cmd(CMD_NONE, 2'($urandom), 8'($urandom), 12'($urandom),
					48'({$urandom, $urandom}), 8'($urandom));
			end
		end
	endtask

	initial begin
		cycles = 0;
		errors = 0;
		idling = 1'b1;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		start = 1'b0;
		cmd = CMD_NONE;
		client_sel = '0;
		buffer_in = '0;
		frame_len = '0;
		dest_mac = '0;
		ip_dest_first = '0;
		m_count = 3'd1;
		m_free = POOL_N;
		for (int i = 0; i < POOL_N; i++) m_stack[i] = 8'(i);
		for (int i = 0; i < CLI_N; i++) begin
			m_mac[i] = '0;
			m_head[i] = 0;
			m_tail[i] = 0;
			m_armed[i] = 1'b1;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_ring_full();
		test_pool_empty();
		setup(3'd4, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
		test_random(140);
		setup(3'd2, 48'h0, 48'hffff_ffff_fffe, 48'h0000_0000_0001, 48'hffff_ffff_ffff);
		test_random(140);
		setup(3'd5, 48'h1, 48'({$urandom, $urandom}), 48'h1, 48'({$urandom, $urandom}));
		test_random(140);
		wait_quiet();
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

[rx_frame_dispatch_buffer_pool_unit.f]
sv/rfdp_pkg.sv
sv/rfdp_ram.sv
sv/rfdp_seq.sv
sv/rx_frame_dispatch_buffer_pool_unit.sv
verif/rx_frame_dispatch_buffer_pool_unit_tb.sv
